// File: design/mbps_pkg.sv
// shared types and constants for the masked byte pattern search block
// no dependencies; every other file in design/ refers to this package by scoped names
package mbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int WIN_DEPTH   = MAX_PATTERN - 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int PIDX_W      = $clog2(MAX_PATTERN);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_MATCH_LIMIT    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [63:0]      pattern_low;
    logic [63:0]      pattern_high;
    logic [15:0]      care_mask;
    logic [LEN_W-1:0] pattern_length;
    logic [15:0]      match_limit;
  } cfg_t;

  // one classified byte handed from the front to the back
  typedef struct packed {
    logic [31:0] start_address;
    logic        hit;
    logic        scan_first;
  } cand_t;

endpackage

// File: design/mbps_front.sv
// front end: byte window shift register and parallel masked compare
// depends on mbps_pkg; pushes classified words into mbps_queue
module mbps_front (
  input  logic                clk,
  input  logic                rst,
  input  mbps_pkg::cfg_t      cfg,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic [31:0]         byte_address,
  input  logic                section_first,
  input  logic                scan_first,
  output logic                push,
  output mbps_pkg::cand_t     cand
);

  logic [7:0]                   window [mbps_pkg::WIN_DEPTH];
  logic [mbps_pkg::LEN_W-1:0]   fill;
  logic [mbps_pkg::LEN_W-1:0]   fill_base;
  logic [mbps_pkg::LEN_W-1:0]   len;
  logic [15:0]                  mask;
  logic [7:0]                   pat      [mbps_pkg::MAX_PATTERN];
  logic [7:0]                   win_byte [mbps_pkg::MAX_PATTERN];
  logic [mbps_pkg::MAX_PATTERN-1:0] miss;
  logic                         full_window;
  logic                         hit;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = mbps_pkg::LEN_W'(1);
    end else if (cfg.pattern_length > mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN)) begin
      len = mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN);
    end else begin
      len = cfg.pattern_length;
    end
    mask      = cfg.care_mask | 16'd1;
    fill_base = (scan_first || section_first) ? '0 : fill;
    full_window = ({1'b0, fill_base} + 6'd1) >= {1'b0, len};
  end

  // position k counts back from the newest byte; it holds pattern byte len-1-k
  genvar k;
  generate
    for (k = 0; k < mbps_pkg::MAX_PATTERN; k++) begin : g_cmp
      logic [mbps_pkg::LEN_W-1:0]  diff;
      logic [mbps_pkg::PIDX_W-1:0] pidx;
      if (k < 8) begin : g_lo
        assign pat[k] = cfg.pattern_low[8*k +: 8];
      end else begin : g_hi
        assign pat[k] = cfg.pattern_high[8*(k-8) +: 8];
      end
      if (k == 0) begin : g_new
        assign win_byte[k] = data_byte;
      end else begin : g_old
        assign win_byte[k] = window[k-1];
      end
      assign diff    = len - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(k);
      assign pidx    = diff[mbps_pkg::PIDX_W-1:0];
      assign miss[k] = (mbps_pkg::LEN_W'(k) < len) && mask[pidx] &&
                       (win_byte[k] != pat[pidx]);
    end
  endgenerate

  assign hit  = full_window && (miss == '0);
  assign push = take && (hit || scan_first);

  always_comb begin
    cand.start_address = byte_address - 32'(len - mbps_pkg::LEN_W'(1));
    cand.hit           = hit;
    cand.scan_first    = scan_first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (take) begin
      if (fill_base < mbps_pkg::LEN_W'(mbps_pkg::WIN_DEPTH)) begin
        fill <= fill_base + mbps_pkg::LEN_W'(1);
      end else begin
        fill <= fill_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      window[0] <= data_byte;
      for (int i = 1; i < mbps_pkg::WIN_DEPTH; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

endmodule

// File: design/mbps_queue.sv
// short register fifo between the front and the back
// depends on mbps_pkg for the entry type and depth
module mbps_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mbps_pkg::cand_t wr_entry,
  input  logic            pop,
  output mbps_pkg::cand_t rd_entry,
  output logic            full,
  output logic            not_empty
);

  mbps_pkg::cand_t              slots [mbps_pkg::QUEUE_DEPTH];
  logic [mbps_pkg::QPTR_W-1:0]  wr_ptr;
  logic [mbps_pkg::QPTR_W-1:0]  rd_ptr;
  logic [mbps_pkg::QCNT_W-1:0]  count;

  assign full      = count == mbps_pkg::QCNT_W'(mbps_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign rd_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mbps_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mbps_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + mbps_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - mbps_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + mbps_pkg::QCNT_W'(1))
    else $error("queue count did not follow a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != '0 && !full) |-> wr_ptr != rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

// File: design/mbps_back.sv
// back end: match counting, limit stop and the result register
// depends on mbps_pkg; pops words from mbps_queue
module mbps_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mbps_pkg::cand_t head,
  output logic            q_pop,
  input  logic [15:0]     match_limit,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     match_address,
  output logic            limit_reached
);

  logic [15:0] match_count;
  logic        stopped;
  logic [15:0] count_base;
  logic [15:0] count_inc;
  logic [15:0] lim;
  logic        stopped_base;
  logic        report;
  logic        reached;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    count_base   = head.scan_first ? 16'd0 : match_count;
    stopped_base = head.scan_first ? 1'b0 : stopped;
    count_inc    = count_base + 16'd1;
    lim          = (match_limit == 16'd0) ? 16'd1 : match_limit;
    report       = head.hit && !stopped_base;
    reached      = count_inc >= lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      match_count <= '0;
      stopped     <= 1'b0;
    end else if (q_pop) begin
      match_count <= report ? count_inc : count_base;
      stopped     <= stopped_base || (report && reached);
      out_valid   <= report;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && report) begin
      match_address <= head.start_address;
      limit_reached <= reached;
    end
  end

  // a word that hit the limit stays visible only while the scan is stopped
  a_limit_stops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && limit_reached) |-> stopped)
    else $error("limit reported without stopping the scan");

  a_stopped_quiet: assert property (@(posedge clk) disable iff (rst)
    (q_pop && stopped && !head.scan_first) |=> !out_valid)
    else $error("result given after the scan stopped");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (q_pop && report) |=> match_count == $past(count_inc))
    else $error("match count did not advance on a reported match");

endmodule

// File: design/masked_byte_pattern_search.sv
// top level of the masked byte pattern search: config registers, front, queue, back
// depends on mbps_pkg, mbps_front, mbps_queue and mbps_back
//
//   port group   direction  handshake            payload
//   input        in         in_valid/in_ready    data_byte, byte_address, section_first,
//                                                scan_first
//   result       out        out_valid/out_ready  match_address, limit_reached
//   config       in         cfg_write            cfg_index, cfg_data
//
// one byte per cycle while in_ready is high; the 16-way byte compare in the front sets the figure
// a result passes from its taken byte through a queue slot and then the output
// register
// a 4-word queue lets the front keep taking bytes while a result waits on out_ready
// in_ready drops only when the queue is full
// rst is synchronous; config returns to its documented defaults, window contents are
// not cleared
module masked_byte_pattern_search (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      data_byte,
  input  logic [31:0]                     byte_address,
  input  logic                            section_first,
  input  logic                            scan_first,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     match_address,
  output logic                            limit_reached,
  input  logic                            cfg_write,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data
);

  mbps_pkg::cfg_t  cfg;
  mbps_pkg::cand_t front_cand;
  mbps_pkg::cand_t head;
  logic            take;
  logic            push;
  logic            q_pop;
  logic            q_full;
  logic            q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low    <= '0;
      cfg.pattern_high   <= '0;
      cfg.care_mask      <= 16'd1;
      cfg.pattern_length <= mbps_pkg::LEN_W'(1);
      cfg.match_limit    <= 16'hffff;
    end else if (cfg_write) begin
      unique case (mbps_pkg::reg_index_t'(cfg_index))
        mbps_pkg::REG_PATTERN_LOW:    cfg.pattern_low    <= cfg_data;
        mbps_pkg::REG_PATTERN_HIGH:   cfg.pattern_high   <= cfg_data;
        mbps_pkg::REG_CARE_MASK:      cfg.care_mask      <= cfg_data[15:0];
        mbps_pkg::REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[mbps_pkg::LEN_W-1:0];
        mbps_pkg::REG_MATCH_LIMIT:    cfg.match_limit    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  mbps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .take          (take),
    .data_byte     (data_byte),
    .byte_address  (byte_address),
    .section_first (section_first),
    .scan_first    (scan_first),
    .push          (push),
    .cand          (front_cand)
  );

  mbps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (front_cand),
    .pop       (q_pop),
    .rd_entry  (head),
    .full      (q_full),
    .not_empty (q_valid)
  );

  mbps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .q_pop         (q_pop),
    .match_limit   (cfg.match_limit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .match_address (match_address),
    .limit_reached (limit_reached)
  );

endmodule
